// ===== src/cps_pkg.sv =====
// Shared types, constants and codes for the companion power supervisor.
`timescale 1ns / 1ps

package cps_pkg;

   // Width of the wrapping millisecond time base and of all timestamps.
   localparam int TIME_W = 32;
   // Width of each configuration register.
   localparam int CFG_W = 32;
   // Width used when comparing an elapsed time against a register.
   localparam int CMP_W = (TIME_W > CFG_W) ? TIME_W : CFG_W;
   localparam int BEACON_W = 32;

   localparam int FUNC_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_ON    = 2'd1,
      FUNC_OFF   = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_BEACON_PERIOD     = 3'd0,
      REG_SHUTDOWN_TIMEOUT  = 3'd1,
      REG_OFF_CONFIRM_DELAY = 3'd2,
      REG_GLITCH_WINDOW     = 3'd3,
      REG_RESTART_DELAY     = 3'd4
   } csr_addr_type;

   localparam logic [CFG_W-1:0] BEACON_PERIOD_RST     = 32'd5000;
   localparam logic [CFG_W-1:0] SHUTDOWN_TIMEOUT_RST  = 32'd20000;
   localparam logic [CFG_W-1:0] OFF_CONFIRM_DELAY_RST = 32'd2000;
   localparam logic [CFG_W-1:0] GLITCH_WINDOW_RST     = 32'd4000;
   localparam logic [CFG_W-1:0] RESTART_DELAY_RST     = 32'd1800000;

   typedef struct packed {
      logic [CFG_W-1:0] beacon_period;
      logic [CFG_W-1:0] shutdown_timeout;
      logic [CFG_W-1:0] off_confirm_delay;
      logic [CFG_W-1:0] glitch_window;
      logic [CFG_W-1:0] restart_delay;
   } cfg_type;

   typedef struct packed {
      logic                power_lost;
      logic [BEACON_W-1:0] beacon_number;
      logic                beacon_fire;
      logic                shutdown_request;
      logic                power_enable;
   } result_type;

endpackage

// ===== src/cps_csr.sv =====
// Configuration register file of the companion power supervisor.
`timescale 1ns / 1ps

module cps_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [cps_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cps_pkg::CFG_W-1:0]    csr_wdata,
   output cps_pkg::cfg_type             cfg
);
   import cps_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_BEACON_PERIOD:     cfg_in.beacon_period     = csr_wdata;
            REG_SHUTDOWN_TIMEOUT:  cfg_in.shutdown_timeout  = csr_wdata;
            REG_OFF_CONFIRM_DELAY: cfg_in.off_confirm_delay = csr_wdata;
            REG_GLITCH_WINDOW:     cfg_in.glitch_window     = csr_wdata;
            REG_RESTART_DELAY:     cfg_in.restart_delay     = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beacon_period     <= BEACON_PERIOD_RST;
         cfg_ff.shutdown_timeout  <= SHUTDOWN_TIMEOUT_RST;
         cfg_ff.off_confirm_delay <= OFF_CONFIRM_DELAY_RST;
         cfg_ff.glitch_window     <= GLITCH_WINDOW_RST;
         cfg_ff.restart_delay     <= RESTART_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/cps_core.sv =====
// Supervisor state registers and the per-tick update logic.
`timescale 1ns / 1ps

module cps_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [cps_pkg::FUNC_W-1:0]   func,
   input  logic                         alive,
   input  cps_pkg::cfg_type             cfg,
   output cps_pkg::result_type          result
);
   import cps_pkg::*;

   logic [TIME_W-1:0]   time_ff, time_in;
   logic                powered_ff, powered_in;
   logic                pending_ff, pending_in;
   logic                dropped_ff, dropped_in;
   logic [TIME_W-1:0]   drop_stamp_ff, drop_stamp_in;
   logic [TIME_W-1:0]   shutdown_stamp_ff, shutdown_stamp_in;
   logic [TIME_W-1:0]   confirm_stamp_ff, confirm_stamp_in;
   logic                confirm_armed_ff, confirm_armed_in;
   logic                booting_ff, booting_in;
   logic [TIME_W-1:0]   beacon_stamp_ff, beacon_stamp_in;
   logic [BEACON_W-1:0] beacon_count_ff, beacon_count_in;

   // Elapsed time since a stamp, widened for comparison with a register.
   function automatic logic [CMP_W-1:0] since(input logic [TIME_W-1:0] now_t,
                                             input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] diff;
      diff = now_t - stamp;
      return CMP_W'(diff);
   endfunction

   always_comb begin
      logic [TIME_W-1:0] now_t;
      logic              fire;
      now_t = time_ff + TIME_W'(1);

      time_in           = now_t;
      powered_in        = powered_ff;
      pending_in        = pending_ff;
      dropped_in        = dropped_ff;
      drop_stamp_in     = drop_stamp_ff;
      shutdown_stamp_in = shutdown_stamp_ff;
      confirm_stamp_in  = confirm_stamp_ff;
      confirm_armed_in  = confirm_armed_ff;
      booting_in        = booting_ff & ~alive;
      beacon_stamp_in   = beacon_stamp_ff;
      beacon_count_in   = beacon_count_ff;
      fire              = 1'b0;

      // Shutdown in progress: wait for a confirmed low alive or the timeout.
      if (pending_in) begin
         if (!alive) begin
            if (!confirm_armed_in) begin
               confirm_armed_in = 1'b1;
               confirm_stamp_in = now_t;
            end
            if (since(now_t, confirm_stamp_in) >= CMP_W'(cfg.off_confirm_delay)) begin
               confirm_armed_in = 1'b0;
               powered_in       = 1'b0;
               pending_in       = 1'b0;
               dropped_in       = 1'b1;
               drop_stamp_in    = now_t;
            end
         end else if (since(now_t, shutdown_stamp_in) > CMP_W'(cfg.shutdown_timeout)) begin
            powered_in    = 1'b0;
            pending_in    = 1'b0;
            dropped_in    = 1'b1;
            drop_stamp_in = now_t;
         end
      end

      // Unexpected loss of the alive pin drops power.
      if (!pending_in && powered_in && !alive) begin
         dropped_in    = 1'b1;
         drop_stamp_in = now_t;
         powered_in    = 1'b0;
      end

      // A short glitch on alive restores power.
      if (dropped_in && alive &&
          since(now_t, drop_stamp_in) < CMP_W'(cfg.glitch_window)) begin
         powered_in = 1'b1;
         pending_in = 1'b0;
         dropped_in = 1'b0;
      end

      // Automatic restart after the long delay.
      if (!powered_in && dropped_in &&
          since(now_t, drop_stamp_in) >= CMP_W'(cfg.restart_delay)) begin
         powered_in = 1'b1;
         pending_in = 1'b0;
         dropped_in = 1'b0;
      end

      case (func_type'(func))
         FUNC_ON: begin
            if (!powered_in) begin
               powered_in = 1'b1;
               pending_in = 1'b0;
               dropped_in = 1'b0;
            end
         end
         FUNC_OFF: begin
            if (powered_in && !pending_in) begin
               pending_in        = 1'b1;
               shutdown_stamp_in = now_t;
            end
         end
         default: ;
      endcase

      if (!booting_in && since(now_t, beacon_stamp_in) >= CMP_W'(cfg.beacon_period)) begin
         fire            = 1'b1;
         beacon_count_in = beacon_count_ff + BEACON_W'(1);
         beacon_stamp_in = now_t;
      end

      result.power_enable     = powered_in;
      result.shutdown_request = pending_in;
      result.beacon_fire      = fire;
      result.beacon_number    = fire ? beacon_count_ff : '0;
      result.power_lost       = dropped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff           <= '0;
         powered_ff        <= 1'b1;
         pending_ff        <= 1'b0;
         dropped_ff        <= 1'b0;
         drop_stamp_ff     <= '0;
         shutdown_stamp_ff <= '0;
         confirm_stamp_ff  <= '0;
         confirm_armed_ff  <= 1'b0;
         booting_ff        <= 1'b1;
         beacon_stamp_ff   <= '0;
         beacon_count_ff   <= '0;
      end else if (step) begin
         time_ff           <= time_in;
         powered_ff        <= powered_in;
         pending_ff        <= pending_in;
         dropped_ff        <= dropped_in;
         drop_stamp_ff     <= drop_stamp_in;
         shutdown_stamp_ff <= shutdown_stamp_in;
         confirm_stamp_ff  <= confirm_stamp_in;
         confirm_armed_ff  <= confirm_armed_in;
         booting_ff        <= booting_in;
         beacon_stamp_ff   <= beacon_stamp_in;
         beacon_count_ff   <= beacon_count_in;
      end
   end

endmodule

// ===== src/companion_power_supervisor.sv =====
// Top level of the companion power supervisor: stream ports and pipeline registers.
// A tick passes through the input register and then the result register; the
// tick update itself is combinational logic between the two.
// Throughput: one tick per cycle, limited only by result back-pressure.
// Reset (synchronous, active high) empties both stages, loads the register
// defaults and returns the supervisor to powered, booting, time zero.
`timescale 1ns / 1ps

module companion_power_supervisor (
   input  logic                             clock,
   input  logic                             reset,
   // Tick input channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cps_pkg::REQ_DATA_W-1:0]   req_tdata,  // [0] alive, rest zero
   input  logic [cps_pkg::FUNC_W-1:0]       req_tuser,  // [1:0] func
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] power_enable, [1] shutdown_request, [2] beacon_fire,
   // [34:3] beacon_number, [35] power_lost, rest zero
   output logic [cps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [cps_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [cps_pkg::CFG_W-1:0]        csr_wdata
);
   import cps_pkg::*;

   localparam int RESULT_W = $bits(result_type);

   cfg_type    cfg;
   result_type result;

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic [FUNC_W-1:0] in_func_ff;
   logic              in_alive_ff;

   // Result register stage.
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;

   logic advance;
   logic step;

   // The result register can take a new value when it is empty or its
   // current value is being transferred out this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   // The input register accepts when it is empty or moving forward.
   assign req_tready = !in_valid_ff || advance;
   // The core processes the held tick exactly when it moves to the result.
   assign step       = in_valid_ff && advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff  <= req_tuser;
         in_alive_ff <= req_tdata[0];
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   cps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cps_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .func   (in_func_ff),
      .alive  (in_alive_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   // The packed struct already orders its fields from power_enable upward.
   assign rsp_tdata  = {{(RSP_DATA_W - RESULT_W){1'b0}}, rsp_data_ff};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the companion power supervisor with a tick-level predictor.
`timescale 1ns / 1ps

module testbench;
   import cps_pkg::*;

   // Number of bits of rsp_tdata that carry result fields.
   localparam int RES_W = $bits(result_type);
   // Register index that the block does not implement; writes to it must be ignored.
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;
   // Cycles to let pass after the last expected result before touching registers.
   localparam int SETTLE_CYCLES = 6;
   // The receiver stops taking results for this long once, after HOLD_AT transfers.
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 200;
   // Watchdog limit on consecutive cycles with no transfer on either channel.
   localparam int STALL_LIMIT = 2000;
   // Only the first mismatches are printed so a broken block cannot flood the log.
   localparam int PRINT_CAP = 50;

   // Scoreboard: it carries its own copy of the supervisor state and registers,
   // predicts one status per accepted tick and compares each received status
   // against the oldest prediction.
   class supply_checker;
      logic [CFG_W-1:0] beacon_period, shut_timeout, off_confirm, glitch_win, restart_wait;
      logic [TIME_W-1:0] now_t, drop_at, shut_at, confirm_at, beacon_at;
      logic [BEACON_W-1:0] beacon_seq;
      logic is_powered, shut_pending, is_dropped, confirm_set, in_boot;
      result_type expected_status[$];
      int errors;

      function new();
         beacon_period = BEACON_PERIOD_RST;
         shut_timeout  = SHUTDOWN_TIMEOUT_RST;
         off_confirm   = OFF_CONFIRM_DELAY_RST;
         glitch_win    = GLITCH_WINDOW_RST;
         restart_wait  = RESTART_DELAY_RST;
         now_t = '0;
         drop_at = '0;
         shut_at = '0;
         confirm_at = '0;
         beacon_at = '0;
         beacon_seq = '0;
         is_powered = 1'b1;
         shut_pending = 1'b0;
         is_dropped = 1'b0;
         confirm_set = 1'b0;
         in_boot = 1'b1;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_BEACON_PERIOD:     beacon_period = value;
            REG_SHUTDOWN_TIMEOUT:  shut_timeout = value;
            REG_OFF_CONFIRM_DELAY: off_confirm = value;
            REG_GLITCH_WINDOW:     glitch_win = value;
            REG_RESTART_DELAY:     restart_wait = value;
            default: ;
         endcase
      endfunction

      // Elapsed ticks since a stamp; the subtraction wraps at the time width.
      function logic [TIME_W-1:0] elapsed(logic [TIME_W-1:0] stamp);
         return now_t - stamp;
      endfunction

      function void power_up();
         is_powered = 1'b1;
         shut_pending = 1'b0;
         is_dropped = 1'b0;
      endfunction

      function void cut_supply();
         is_powered = 1'b0;
         shut_pending = 1'b0;
         is_dropped = 1'b1;
         drop_at = now_t;
      endfunction

      // One accepted tick: advance time, run the supervision steps in order and
      // queue the status the block must report for it.
      function void predict_tick(func_type f, logic alive);
         result_type r;
         r = '0;
         now_t = now_t + 1'b1;
         if (in_boot && alive)
            in_boot = 1'b0;
         if (shut_pending) begin
            if (!alive) begin
               if (!confirm_set) begin
                  confirm_set = 1'b1;
                  confirm_at = now_t;
               end
               if (CMP_W'(elapsed(confirm_at)) >= CMP_W'(off_confirm)) begin
                  confirm_set = 1'b0;
                  cut_supply();
               end
            end else if (CMP_W'(elapsed(shut_at)) > CMP_W'(shut_timeout)) begin
               // A timed-out cut leaves the confirm timer armed with its old stamp.
               cut_supply();
            end
         end
         if (!shut_pending && is_powered && !alive) begin
            is_dropped = 1'b1;
            drop_at = now_t;
            is_powered = 1'b0;
         end
         if (is_dropped && alive && CMP_W'(elapsed(drop_at)) < CMP_W'(glitch_win))
            power_up();
         if (!is_powered && is_dropped && CMP_W'(elapsed(drop_at)) >= CMP_W'(restart_wait))
            power_up();
         case (f)
            FUNC_ON: begin
               if (!is_powered)
                  power_up();
            end
            FUNC_OFF: begin
               if (is_powered && !shut_pending) begin
                  shut_pending = 1'b1;
                  shut_at = now_t;
               end
            end
            default: ;
         endcase
         if (!in_boot && CMP_W'(elapsed(beacon_at)) >= CMP_W'(beacon_period)) begin
            r.beacon_fire = 1'b1;
            r.beacon_number = beacon_seq;
            beacon_seq = beacon_seq + 1'b1;
            beacon_at = now_t;
         end
         r.power_enable = is_powered;
         r.shutdown_request = shut_pending;
         r.power_lost = is_dropped;
         expected_status.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                        act_v);
         end
      endfunction

      function void check_status(result_type got);
         result_type want;
         if (expected_status.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: status with no tick pending, expected none, actual %h", $time,
                        got);
            return;
         end
         want = expected_status.pop_front();
         compare_field("power_enable", 32'(want.power_enable), 32'(got.power_enable));
         compare_field("shutdown_request", 32'(want.shutdown_request),
                       32'(got.shutdown_request));
         compare_field("beacon_fire", 32'(want.beacon_fire), 32'(got.beacon_fire));
         compare_field("beacon_number", 32'(want.beacon_number), 32'(got.beacon_number));
         compare_field("power_lost", 32'(want.power_lost), 32'(got.power_lost));
      endfunction

      function int pending();
         return expected_status.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CFG_W-1:0] csr_wdata;

   supply_checker ledger;
   int ticks_sent = 0;      // total tick transfers so far
   int phase_ticks = 0;     // tick transfers in the current phase
   int status_seen = 0;     // total status transfers so far
   logic alive_level = 1'b1;

   companion_power_supervisor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one tick and wait for its transfer. Between ticks the sender idles for
   // a random number of cycles, except in every fourth window of 50 ticks, which
   // runs back to back. When the gap is zero, tvalid simply stays high.
   task automatic send_tick(func_type f, logic alive);
      int gap;
      if ((ticks_sent / 50) % 4 == 3)
         gap = 0;
      else
         gap = $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(alive);
      req_tuser <= f;
      do @(posedge clock); while (req_tready !== 1'b1);
      ledger.predict_tick(f, alive);
      ticks_sent++;
      phase_ticks++;
   endtask

   // Wait until every predicted status has come back and the pipeline is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drive one register write; the enable is lowered by the caller after a batch,
   // so that back-to-back writes never assign it twice in one step.
   task automatic put_reg(logic [CSR_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      ledger.write_reg(idx, value);
   endtask

   // Load a whole register setting while the block is idle, plus a write to an
   // index that does not exist, which must change nothing.
   task automatic apply_settings(logic [CFG_W-1:0] period, logic [CFG_W-1:0] timeout,
                                 logic [CFG_W-1:0] confirm, logic [CFG_W-1:0] window,
                                 logic [CFG_W-1:0] restart);
      settle();
      put_reg(REG_BEACON_PERIOD, period);
      put_reg(REG_UNUSED, $urandom());
      put_reg(REG_SHUTDOWN_TIMEOUT, timeout);
      put_reg(REG_OFF_CONFIRM_DELAY, confirm);
      put_reg(REG_GLITCH_WINDOW, window);
      put_reg(REG_RESTART_DELAY, restart);
      csr_we <= 1'b0;
      phase_ticks = 0;
   endtask

   function automatic func_type draw_func();
      int r;
      r = $urandom_range(0, 15);
      if (r < 11)
         return FUNC_TICK;
      else if (r < 13)
         return FUNC_ON;
      else if (r < 15)
         return FUNC_OFF;
      return FUNC_SPARE;
   endfunction

   // A well-formed shutdown: request power-off, keep running a while, then let the
   // alive pin fall for a random number of ticks before it comes back.
   task automatic shutdown_run();
      int lead;
      int low_len;
      lead = $urandom_range(0, 8);
      low_len = $urandom_range(0, 12);
      send_tick(FUNC_OFF, 1'b1);
      repeat (lead) send_tick(($urandom_range(0, 5) == 0) ? draw_func() : FUNC_TICK, 1'b1);
      repeat (low_len) send_tick(FUNC_TICK, 1'b0);
      alive_level = 1'b1;
   endtask

   // A short loss of the alive pin that may or may not fall inside the glitch window.
   task automatic glitch_run();
      int low_len;
      low_len = $urandom_range(1, 6);
      repeat (low_len) send_tick(FUNC_TICK, 1'b0);
      alive_level = 1'b1;
   endtask

   // Random ticks with a sticky alive level and a random mix of commands.
   task automatic noise_run();
      int len;
      len = $urandom_range(3, 12);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0)
            alive_level = ~alive_level;
         send_tick(draw_func(), alive_level);
      end
   endtask

   task automatic random_phase(int count);
      int pick;
      while (phase_ticks < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            shutdown_run();
         else if (pick < 7)
            glitch_run();
         else
            noise_run();
      end
   endtask

   // Receiver: takes status transfers with random stalls, runs without stalls in
   // some windows, and once holds off for a long stretch so the block fills up and
   // stops taking ticks while the sender keeps offering.
   initial begin : status_sink
      int gap;
      result_type got;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (status_seen == HOLD_AT)
            gap = HOLD_CYCLES;
         else if ((status_seen / 40) % 3 == 1)
            gap = 0;
         else
            gap = $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = rsp_tdata[RES_W-1:0];
         ledger.check_status(got);
         status_seen++;
      end
   end

   // Watchdog: ends the run if nothing is transferred on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_TICK;
      csr_we = 1'b0;
      csr_addr = REG_BEACON_PERIOD;
      csr_wdata = '0;
      ledger = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: boot hold with the pin low, the unused func code, redundant
      // commands, and a shutdown request that arms the confirm timer.
      send_tick(FUNC_TICK, 1'b0);
      send_tick(FUNC_SPARE, 1'b0);
      send_tick(FUNC_ON, 1'b0);
      send_tick(FUNC_OFF, 1'b0);
      send_tick(FUNC_TICK, 1'b1);
      send_tick(FUNC_OFF, 1'b1);
      send_tick(FUNC_OFF, 1'b1);
      send_tick(FUNC_TICK, 1'b0);
      send_tick(FUNC_ON, 1'b1);
      send_tick(FUNC_ON, 1'b1);

      // Zero registers apart from the shutdown timeout: a beacon every tick, an immediate
      // confirmed cut, no glitch restore, and a restart in the same tick as the loss.
      apply_settings('0, 32'd2, '0, '0, '0);
      send_tick(FUNC_TICK, 1'b1);
      send_tick(FUNC_OFF, 1'b1);
      send_tick(FUNC_TICK, 1'b0);
      send_tick(FUNC_TICK, 1'b0);
      send_tick(FUNC_SPARE, 1'b1);

      // Stale confirmation: the timer is armed by one low tick, the cut then comes
      // from the timeout, and the next shutdown sees the old stamp.
      apply_settings(32'd1, 32'd2, 32'd3, 32'd2, 32'd6);
      send_tick(FUNC_OFF, 1'b1);
      send_tick(FUNC_TICK, 1'b0);
      send_tick(FUNC_TICK, 1'b1);
      send_tick(FUNC_TICK, 1'b1);
      send_tick(FUNC_TICK, 1'b1);
      send_tick(FUNC_ON, 1'b1);
      send_tick(FUNC_OFF, 1'b1);
      send_tick(FUNC_TICK, 1'b0);
      send_tick(FUNC_TICK, 1'b1);

      // Largest register values: nothing ever times out.
      apply_settings('1, '1, '1, '1, '1);
      random_phase(60);

      // Full-width random values, mostly far beyond the run length.
      apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      random_phase(50);

      // Small settings that let every timer expire many times.
      for (i = 0; i < 8; i++) begin
         apply_settings($urandom_range(0, 12), $urandom_range(0, 16), $urandom_range(0, 8),
                        $urandom_range(0, 8), $urandom_range(0, 40));
         random_phase(110);
      end

      settle();
      if (ledger.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
